### src/dott_pkg.sv
// Shared types, codes and helpers for the deadline ordered timer table.
// Used by dott_front, dott_engine, the top level and the checker. No dependencies.
package dott_pkg;

   // Request codes on the input port.
   localparam logic [2:0] REQ_ADD     = 3'd0;
   localparam logic [2:0] REQ_CANCEL  = 3'd1;
   localparam logic [2:0] REQ_REFRESH = 3'd2;
   localparam logic [2:0] REQ_RESET   = 3'd3;
   localparam logic [2:0] REQ_EXPIRE  = 3'd4;

   // Internal operation codes after classification.
   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_RESET   = 3'd3;
   localparam logic [2:0] OP_EXPIRE  = 3'd4;
   localparam logic [2:0] OP_NOP     = 3'd5;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_ARMED = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NONE      = 3'd3;
   localparam logic [2:0] ST_FIRED     = 3'd4;

   // At most this many slots fire in one expire scan.
   localparam int MAX_FIRE = 32;

   typedef struct packed {
      logic [2:0]  op;
      logic [4:0]  slot;
      logic [31:0] interval;
      logic        periodic;
      logic        from_now;
      logic [63:0] now_ms;
   } cmd_type;

   typedef struct packed {
      logic [4:0]  slot_id;
      logic [2:0]  status;
      logic        inserted_front;
      logic [63:0] first_deadline;
      logic        any_armed;
      logic        last;
   } res_type;

   // Sum that saturates at all ones.
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

endpackage

### src/dott_front.sv
// Front end of the timer table: accepts requests, classifies them and holds
// them in a two-entry command queue. Depends on dott_pkg.
module dott_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic [4:0]        req_slot,
   input  logic [31:0]       req_new_interval,
   input  logic              req_periodic,
   input  logic              req_from_now,
   input  logic [63:0]       req_now_ms,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output dott_pkg::cmd_type cmd
);
   import dott_pkg::*;

   cmd_type    q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push;

   always_comb begin
      unique case (req_type)
         REQ_ADD:     new_cmd.op = OP_ADD;
         REQ_CANCEL:  new_cmd.op = OP_CANCEL;
         REQ_REFRESH: new_cmd.op = OP_REFRESH;
         REQ_RESET:   new_cmd.op = OP_RESET;
         REQ_EXPIRE:  new_cmd.op = OP_EXPIRE;
         default:     new_cmd.op = OP_NOP;
      endcase
      new_cmd.slot     = req_slot;
      new_cmd.interval = req_new_interval;
      new_cmd.periodic = req_periodic;
      new_cmd.from_now = req_from_now;
      new_cmd.now_ms   = req_now_ms;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = cmd_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_cmd;
      end
   end

endmodule

### src/dott_engine.sv
// Back end of the timer table: slot flags, interval and deadline memories, and
// the sequencer that updates slots, scans for the front and emits results. Depends on dott_pkg.
module dott_engine #(
   parameter int SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  dott_pkg::cmd_type cmd,
   output logic              res_valid,
   input  logic              res_ready,
   output dott_pkg::res_type res
);
   import dott_pkg::*;

   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int OW  = $clog2(MAX_FIRE + 1);
   localparam int EW  = $clog2(MAX_FIRE);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHK   = 4'd1;
   localparam logic [3:0] S_MOD1  = 4'd2;
   localparam logic [3:0] S_MOD2  = 4'd3;
   localparam logic [3:0] S_SEL   = 4'd4;
   localparam logic [3:0] S_APPLY = 4'd5;
   localparam logic [3:0] S_FRONT = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;

   logic [63:0] dl_mem [SLOTS];
   logic [31:0] iv_mem [SLOTS];
   logic [63:0] rd_dl_ff;
   logic [31:0] rd_iv_ff;
   logic [SW-1:0] rd_addr;
   logic          dl_we, iv_we;
   logic [SW-1:0] dl_wa, iv_wa;
   logic [63:0]   dl_wd;
   logic [31:0]   iv_wd;

   logic [3:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [SLOTS-1:0] armed_ff, armed_in;
   logic [SLOTS-1:0] per_ff, per_in;
   logic [SLOTS-1:0] picked_ff, picked_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             pv_ff, pv_in;
   logic [SW-1:0]    pidx_ff, pidx_in;
   logic             bv_ff, bv_in;
   logic [SW-1:0]    bidx_ff, bidx_in;
   logic [63:0]      bdl_ff, bdl_in;
   logic [OW-1:0]    ocnt_ff, ocnt_in;
   logic [EW-1:0]    ecnt_ff, ecnt_in;
   logic [4:0]       rsid_ff, rsid_in;
   logic [2:0]       rst_ff, rst_in;
   logic             fchk_ff, fchk_in;
   logic [SW-1:0]    ridx_ff, ridx_in;
   logic [63:0]      start_ff, start_in;
   logic [SW-1:0]    order_ff [MAX_FIRE];
   logic             order_we;

   logic [6:0]    sl_wide;
   logic [SW-1:0] sl_idx;
   logic          sl_ok;
   logic          any_free;
   logic [SW-1:0] free_idx;
   logic          scan_done;
   logic [6:0]    fire_wide;
   logic [SW-1:0] fire_idx;

   assign sl_wide   = 7'(cmd_ff.slot);
   assign sl_idx    = sl_wide[SW-1:0];
   assign sl_ok     = (sl_wide < 7'(SLOTS)) && armed_ff[sl_idx];
   assign scan_done = (cnt_ff == CW'(SLOTS)) && !pv_ff;
   assign fire_idx  = order_ff[ecnt_ff];
   assign fire_wide = 7'(fire_idx);

   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!armed_ff[i]) begin
            any_free = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      if (state_ff == S_SEL || state_ff == S_APPLY || state_ff == S_FRONT) begin
         rd_addr = cnt_ff[SW-1:0];
      end else begin
         rd_addr = sl_idx;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      armed_in  = armed_ff;
      per_in    = per_ff;
      picked_in = picked_ff;
      cnt_in    = cnt_ff;
      pv_in     = 1'b0;
      pidx_in   = pidx_ff;
      bv_in     = bv_ff;
      bidx_in   = bidx_ff;
      bdl_in    = bdl_ff;
      ocnt_in   = ocnt_ff;
      ecnt_in   = ecnt_ff;
      rsid_in   = rsid_ff;
      rst_in    = rst_ff;
      fchk_in   = fchk_ff;
      ridx_in   = ridx_ff;
      start_in  = start_ff;
      order_we  = 1'b0;
      dl_we     = 1'b0;
      iv_we     = 1'b0;
      dl_wa     = sl_idx;
      iv_wa     = sl_idx;
      dl_wd     = '0;
      iv_wd     = cmd_ff.interval;
      cmd_pop   = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      // Slot scans issue one memory read per cycle; the data is processed in the cycle after.
      if (state_ff == S_SEL || state_ff == S_APPLY || state_ff == S_FRONT) begin
         if (cnt_ff != CW'(SLOTS)) begin
            pv_in   = 1'b1;
            pidx_in = cnt_ff[SW-1:0];
            cnt_in  = cnt_ff + CW'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            bv_in  = 1'b0;
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               ocnt_in = '0;
               fchk_in = 1'b0;
               rsid_in = 5'd0;
               rst_in  = ST_OK;
               unique case (cmd.op)
                  OP_ADD: begin
                     state_in = S_FRONT;
                     if (any_free) begin
                        armed_in[free_idx] = 1'b1;
                        per_in[free_idx]   = cmd.periodic;
                        dl_we   = 1'b1;
                        iv_we   = 1'b1;
                        dl_wa   = free_idx;
                        iv_wa   = free_idx;
                        dl_wd   = sat_add(cmd.now_ms, 64'(cmd.interval));
                        iv_wd   = cmd.interval;
                        fchk_in = 1'b1;
                        ridx_in = free_idx;
                        rsid_in = 5'(7'(free_idx));
                     end else begin
                        rst_in = ST_FULL;
                     end
                  end
                  OP_CANCEL, OP_REFRESH, OP_RESET: begin
                     state_in = S_CHK;
                  end
                  OP_EXPIRE: begin
                     state_in  = S_SEL;
                     picked_in = '0;
                  end
                  default: begin
                     state_in = S_FRONT;
                  end
               endcase
            end
         end
         S_CHK: begin
            rsid_in = cmd_ff.slot;
            ridx_in = sl_idx;
            if (!sl_ok) begin
               rst_in   = ST_NOT_ARMED;
               state_in = S_FRONT;
            end else if (cmd_ff.op == OP_CANCEL) begin
               armed_in[sl_idx] = 1'b0;
               state_in = S_FRONT;
            end else begin
               fchk_in  = 1'b1;
               state_in = S_MOD1;
            end
         end
         S_MOD1: begin
            if (cmd_ff.op == OP_REFRESH) begin
               dl_we    = 1'b1;
               dl_wd    = sat_add(cmd_ff.now_ms, 64'(rd_iv_ff));
               state_in = S_FRONT;
            end else begin
               if (cmd_ff.from_now) begin
                  start_in = cmd_ff.now_ms;
               end else if (rd_dl_ff >= 64'(rd_iv_ff)) begin
                  start_in = rd_dl_ff - 64'(rd_iv_ff);
               end else begin
                  start_in = '0;
               end
               state_in = S_MOD2;
            end
         end
         S_MOD2: begin
            dl_we    = 1'b1;
            iv_we    = 1'b1;
            dl_wd    = sat_add(start_ff, 64'(cmd_ff.interval));
            state_in = S_FRONT;
         end
         S_SEL: begin
            if (pv_ff && armed_ff[pidx_ff] && !picked_ff[pidx_ff] &&
                rd_dl_ff <= cmd_ff.now_ms && (!bv_ff || rd_dl_ff < bdl_ff)) begin
               bv_in   = 1'b1;
               bidx_in = pidx_ff;
               bdl_in  = rd_dl_ff;
            end
            if (scan_done) begin
               cnt_in = '0;
               bv_in  = 1'b0;
               if (bv_ff) begin
                  picked_in[bidx_ff] = 1'b1;
                  order_we = 1'b1;
                  ocnt_in  = ocnt_ff + OW'(1);
                  if (ocnt_ff == OW'(MAX_FIRE - 1)) begin
                     state_in = S_APPLY;
                  end
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            if (pv_ff && picked_ff[pidx_ff]) begin
               if (per_ff[pidx_ff]) begin
                  dl_we = 1'b1;
                  dl_wa = pidx_ff;
                  dl_wd = sat_add(cmd_ff.now_ms, 64'(rd_iv_ff));
               end else begin
                  armed_in[pidx_ff] = 1'b0;
               end
            end
            if (scan_done) begin
               cnt_in   = '0;
               bv_in    = 1'b0;
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            if (pv_ff && armed_ff[pidx_ff] && (!bv_ff || rd_dl_ff < bdl_ff)) begin
               bv_in   = 1'b1;
               bidx_in = pidx_ff;
               bdl_in  = rd_dl_ff;
            end
            if (scan_done) begin
               ecnt_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            res_valid          = 1'b1;
            res.first_deadline = bv_ff ? bdl_ff : '1;
            res.any_armed      = bv_ff;
            if (cmd_ff.op == OP_EXPIRE && ocnt_ff != '0) begin
               res.slot_id        = fire_wide[4:0];
               res.status         = ST_FIRED;
               res.inserted_front = per_ff[fire_idx] && bv_ff && (bidx_ff == fire_idx);
               res.last           = (OW'(ecnt_ff) + OW'(1) == ocnt_ff);
            end else if (cmd_ff.op == OP_EXPIRE) begin
               res.status = ST_NONE;
               res.last   = 1'b1;
            end else begin
               res.slot_id        = rsid_ff;
               res.status         = rst_ff;
               res.inserted_front = fchk_ff && bv_ff && (bidx_ff == ridx_ff);
               res.last           = 1'b1;
            end
            if (res_ready) begin
               if (res.last) begin
                  state_in = S_IDLE;
               end else begin
                  ecnt_in = ecnt_ff + EW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         armed_ff <= '0;
         per_ff   <= '0;
         pv_ff    <= 1'b0;
         cnt_ff   <= '0;
         bv_ff    <= 1'b0;
         ocnt_ff  <= '0;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         per_ff   <= per_in;
         pv_ff    <= pv_in;
         cnt_ff   <= cnt_in;
         bv_ff    <= bv_in;
         ocnt_ff  <= ocnt_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      picked_ff <= picked_in;
      pidx_ff   <= pidx_in;
      bidx_ff   <= bidx_in;
      bdl_ff    <= bdl_in;
      rsid_ff   <= rsid_in;
      rst_ff    <= rst_in;
      fchk_ff   <= fchk_in;
      ridx_ff   <= ridx_in;
      start_ff  <= start_in;
      if (order_we) begin
         order_ff[ocnt_ff[EW-1:0]] <= bidx_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_dl_ff <= dl_mem[rd_addr];
      rd_iv_ff <= iv_mem[rd_addr];
      if (dl_we) begin
         dl_mem[dl_wa] <= dl_wd;
      end
      if (iv_we) begin
         iv_mem[iv_wa] <= iv_wd;
      end
   end

endmodule

### src/deadline_ordered_timer_table.sv
// Top level of the deadline ordered timer table: front end, command queue,
// slot engine and result register. Depends on dott_pkg, dott_front, dott_engine.
//
// The table keeps SLOTS timer slots. Add arms the lowest free slot, cancel
// disarms one, refresh re-arms one at now plus its interval, and reset interval
// installs a new interval counted from now or from the old start. An expire scan
// fires every armed slot whose deadline is at most now, earliest first, ties to
// the lower slot, at most 32 per scan. Every result carries the earliest armed
// deadline and the armed summary after the whole request. Timing: requests go
// into a two-entry queue, so up to two can be accepted while the engine works.
// The engine reads the deadline memory one slot per cycle. Add and unknown codes
// go straight to a front scan, cancel first checks its slot, refresh checks and
// writes a new deadline, and reset interval checks, computes the start and
// writes. An expire scan makes one select pass per fired slot, plus a final
// pass that finds none when fewer than 32 fire, then an apply pass and a front
// pass. Each request then emits its results. Stalls on the result port hold the
// engine in its emit step. A finished result sits in an output register while
// the engine already begins the next queued request.
module deadline_ordered_timer_table #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_slot,
   input  logic [31:0] req_new_interval,
   input  logic        req_periodic,
   input  logic        req_from_now,
   input  logic [63:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_slot_id,
   output logic [2:0]  rsp_status,
   output logic        rsp_inserted_front,
   output logic [63:0] rsp_first_deadline,
   output logic        rsp_any_armed,
   output logic        rsp_last
);
   import dott_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   res_type res;
   logic    res_valid;
   logic    res_ready;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;

   dott_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot         (req_slot),
      .req_new_interval (req_new_interval),
      .req_periodic     (req_periodic),
      .req_from_now     (req_from_now),
      .req_now_ms       (req_now_ms),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd              (cmd)
   );

   dott_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The output register takes a new result whenever it is empty or its
   // current transfer completes in this cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_id        = rsp_ff.slot_id;
   assign rsp_status         = rsp_ff.status;
   assign rsp_inserted_front = rsp_ff.inserted_front;
   assign rsp_first_deadline = rsp_ff.first_deadline;
   assign rsp_any_armed      = rsp_ff.any_armed;
   assign rsp_last           = rsp_ff.last;

endmodule

### src/dott_checker.sv
// Port-level checks for the deadline ordered timer table, and the bind that
// attaches them to the top level. Depends on dott_pkg.
module dott_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_slot_id,
   input logic [2:0]  rsp_status,
   input logic        rsp_inserted_front,
   input logic [63:0] rsp_first_deadline,
   input logic        rsp_any_armed,
   input logic        rsp_last
);
   import dott_pkg::*;

   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_deadline)
      && $stable(rsp_slot_id) && $stable(rsp_status))
      else $error("result changed while stalled");

   // With nothing armed the earliest deadline reads as all ones.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_armed |-> rsp_first_deadline == '1)
      else $error("empty table reports a deadline");

   // A slot reported at the front means something is armed and the status is ok or fired.
   a_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted_front |-> rsp_any_armed
      && (rsp_status == ST_OK || rsp_status == ST_FIRED))
      else $error("front flag without an armed slot");

   // Table full and nothing expired are single results on slot zero without the front flag.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NONE)
      |-> rsp_last && rsp_slot_id == 5'd0 && !rsp_inserted_front)
      else $error("malformed error result");

endmodule

bind deadline_ordered_timer_table dott_checker u_dott_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_slot_id        (rsp_slot_id),
   .rsp_status         (rsp_status),
   .rsp_inserted_front (rsp_inserted_front),
   .rsp_first_deadline (rsp_first_deadline),
   .rsp_any_armed      (rsp_any_armed),
   .rsp_last           (rsp_last)
);
